>>> rtl/core/ifd_pkg.sv
// Shared types and constants of the IPv4 forwarding decision block.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package ifd_pkg;

  localparam int ROUTES_DEFAULT = 16;
  localparam int PORTS_DEFAULT  = 4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ADDR_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ADDR_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ADDR_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ADDR_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ENABLE = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_IFACE_ADDR [4] = '{
    CFG_IFACE_ADDR_0, CFG_IFACE_ADDR_1, CFG_IFACE_ADDR_2, CFG_IFACE_ADDR_3
  };

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_DECIDE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ACT_WRITE         = 3'd0,
    ACT_DROP          = 3'd1,
    ACT_ECHO          = 3'd2,
    ACT_PORT_UNREACH  = 3'd3,
    ACT_NET_UNREACH   = 3'd4,
    ACT_TIME_EXCEEDED = 3'd5,
    ACT_FORWARD       = 3'd6
  } action_t;

  // One transaction as it travels down the route cells.
  typedef struct packed {
    logic        valid;
    op_t         opcode;
    logic [3:0]  entry_index;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [1:0]  entry_port;
    logic [31:0] dest_addr;
    logic [7:0]  ttl;
    logic        requeued;
    logic        local_hit;
    action_t     local_action;
    logic [1:0]  local_port;
    logic        found;
    logic [31:0] best_mask;
    logic [31:0] best_gateway;
    logic [1:0]  best_port;
  } route_tok_t;

endpackage

`default_nettype wire

>>> rtl/core/ifd_head.sv
// Entry stage: interface configuration registers, local address match and
// the register that launches a transaction into the route cells. Uses ifd_pkg.
`default_nettype none

module ifd_head #(
  parameter int PORTS = ifd_pkg::PORTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             adv,
  input  wire logic                             cfg_write,
  input  wire logic [ifd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ifd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             item_valid,
  input  wire logic                             opcode,
  input  wire logic [3:0]                       entry_index,
  input  wire logic [31:0]                      entry_dest,
  input  wire logic [31:0]                      entry_mask,
  input  wire logic [31:0]                      entry_gateway,
  input  wire logic [1:0]                       entry_port,
  input  wire logic [31:0]                      dest_addr,
  input  wire logic [7:0]                       protocol,
  input  wire logic [7:0]                       ttl,
  input  wire logic [7:0]                       icmp_kind,
  input  wire logic                             icmp_ok,
  input  wire logic                             requeued,
  output ifd_pkg::route_tok_t                   tok_out
);

  logic [31:0]      iface_addr [PORTS];
  logic [PORTS-1:0] iface_enable;

  logic                hit;
  logic [1:0]          hit_port;
  ifd_pkg::route_tok_t tok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      iface_enable <= '0;
      for (int i = 0; i < PORTS; i++) begin
        iface_addr[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == ifd_pkg::CFG_IFACE_ENABLE) begin
        iface_enable <= cfg_data[PORTS-1:0];
      end
      for (int i = 0; i < PORTS; i++) begin
        if (cfg_index == ifd_pkg::CFG_IFACE_ADDR[i]) begin
          iface_addr[i] <= cfg_data;
        end
      end
    end
  end

  // Walk from the top down so that the lowest enabled interface wins.
  always_comb begin
    hit      = 1'b0;
    hit_port = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (iface_enable[i] && iface_addr[i] == dest_addr) begin
        hit      = 1'b1;
        hit_port = 2'(i);
      end
    end
  end

  always_comb begin
    tok_next               = '0;
    tok_next.valid         = item_valid;
    tok_next.opcode        = ifd_pkg::op_t'(opcode);
    tok_next.entry_index   = entry_index;
    tok_next.entry_dest    = entry_dest;
    tok_next.entry_mask    = entry_mask;
    tok_next.entry_gateway = entry_gateway;
    tok_next.entry_port    = entry_port;
    tok_next.dest_addr     = dest_addr;
    tok_next.ttl           = ttl;
    tok_next.requeued      = requeued;
    tok_next.local_hit     = hit;
    tok_next.local_action  = ifd_pkg::ACT_DROP;
    tok_next.local_port    = '0;
    if (protocol == ifd_pkg::PROTO_ICMP) begin
      if (icmp_ok && icmp_kind == ifd_pkg::ICMP_ECHO_REQUEST) begin
        tok_next.local_action = ifd_pkg::ACT_ECHO;
        tok_next.local_port   = hit_port;
      end
    end else if (protocol inside {ifd_pkg::PROTO_TCP, ifd_pkg::PROTO_UDP}) begin
      tok_next.local_action = ifd_pkg::ACT_PORT_UNREACH;
      tok_next.local_port   = hit_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ifd_cell.sv
// One route cell: holds a single route entry, takes a write aimed at its slot
// and updates the running longest prefix match of a passing lookup. Uses ifd_pkg.
`default_nettype none

module ifd_cell #(
  parameter int INDEX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  ifd_pkg::route_tok_t tok_in,
  output ifd_pkg::route_tok_t tok_out
);

  logic [31:0] route_dest;
  logic [31:0] route_mask;
  logic [31:0] route_gateway;
  logic [1:0]  route_port;

  logic                write_hit;
  ifd_pkg::route_tok_t tok_next;

  assign write_hit = tok_in.valid && tok_in.opcode == ifd_pkg::OP_WRITE &&
                     int'(tok_in.entry_index) == INDEX;

  // A zero mask can never beat the running best, so an empty slot never matches.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.opcode == ifd_pkg::OP_DECIDE &&
        (route_mask & tok_in.dest_addr) == route_dest &&
        route_mask > tok_in.best_mask) begin
      tok_next.found        = 1'b1;
      tok_next.best_mask    = route_mask;
      tok_next.best_gateway = route_gateway;
      tok_next.best_port    = route_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_mask <= '0;
    end else if (adv && write_hit) begin
      route_dest    <= tok_in.entry_dest;
      route_mask    <= tok_in.entry_mask;
      route_gateway <= tok_in.entry_gateway;
      route_port    <= tok_in.entry_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

  a_found_has_mask: assert property (@(posedge clk) disable iff (rst)
    tok_out.valid && tok_out.found |-> tok_out.best_mask != '0)
    else $error("match flagged with a zero best mask");

  a_mask_only_by_write: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(route_mask) |-> $past(adv && write_hit))
    else $error("route mask changed without a write to this slot");

endmodule

`default_nettype wire

>>> rtl/core/ifd_tail.sv
// Result stage: turns the transaction leaving the last route cell into the
// action code and holds it in the output register. Uses ifd_pkg.
`default_nettype none

module ifd_tail (
  input  wire logic           clk,
  input  wire logic           rst,
  input  ifd_pkg::route_tok_t tok_in,
  input  wire logic           result_stall,
  output logic                adv,
  output logic                result_valid,
  output logic [2:0]          action,
  output logic [1:0]          out_port,
  output logic [31:0]         next_hop,
  output logic [7:0]          new_ttl,
  output logic [1:0]          local_port
);

  ifd_pkg::action_t act_next;
  logic [1:0]       out_port_next;
  logic [31:0]      next_hop_next;
  logic [7:0]       new_ttl_next;
  logic [1:0]       local_port_next;
  logic [7:0]       ttl_dec;

  // The whole chain moves only when the output register is free or drained.
  assign adv = !result_valid || !result_stall;

  assign ttl_dec = tok_in.requeued ? tok_in.ttl : tok_in.ttl - 8'd1;

  always_comb begin
    act_next        = ifd_pkg::ACT_WRITE;
    out_port_next   = '0;
    next_hop_next   = '0;
    new_ttl_next    = '0;
    local_port_next = '0;
    if (tok_in.opcode == ifd_pkg::OP_DECIDE) begin
      if (tok_in.local_hit) begin
        act_next        = tok_in.local_action;
        local_port_next = tok_in.local_port;
      end else if (!tok_in.found) begin
        act_next = ifd_pkg::ACT_NET_UNREACH;
      end else begin
        next_hop_next = tok_in.best_gateway;
        new_ttl_next  = ttl_dec;
        if (ttl_dec == 8'd0) begin
          act_next = ifd_pkg::ACT_TIME_EXCEEDED;
        end else begin
          act_next      = ifd_pkg::ACT_FORWARD;
          out_port_next = tok_in.best_port;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= tok_in.valid;
      action       <= act_next;
      out_port     <= out_port_next;
      next_hop     <= next_hop_next;
      new_ttl      <= new_ttl_next;
      local_port   <= local_port_next;
    end
  end

  a_forward_ttl_live: assert property (@(posedge clk) disable iff (rst)
    result_valid && action == ifd_pkg::ACT_FORWARD |-> new_ttl != 8'd0)
    else $error("forward issued with an expired TTL");

  a_expired_no_port: assert property (@(posedge clk) disable iff (rst)
    result_valid && action == ifd_pkg::ACT_TIME_EXCEEDED |->
      new_ttl == 8'd0 && out_port == 2'd0 && local_port == 2'd0)
    else $error("time exceeded result carries stray fields");

endmodule

`default_nettype wire

>>> rtl/core/ipv4_forwarding_decision.sv
// IPv4 forwarding decision. Every transaction (route write or header lookup)
// enters an entry stage, then walks a row of ROUTES route cells, one cell per
// cycle while the row is not held, and lands in an output register. The entry
// stage, each cell and the output stage are all registers; a new transaction
// is taken in every cycle that item_stall is low. Each cell holds one route
// entry; a write updates its slot when it passes, so later transactions see it
// and earlier ones do not. While a result is held by result_stall the whole
// row stands still and item_stall is raised. Interface addresses and enables
// are read at the entry stage.
// Route masks reset to zero, so no entry matches until written.
`default_nettype none

module ipv4_forwarding_decision #(
  parameter int ROUTES = ifd_pkg::ROUTES_DEFAULT,
  parameter int PORTS  = ifd_pkg::PORTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ifd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ifd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic                             opcode,
  input  wire logic [3:0]                       entry_index,
  input  wire logic [31:0]                      entry_dest,
  input  wire logic [31:0]                      entry_mask,
  input  wire logic [31:0]                      entry_gateway,
  input  wire logic [1:0]                       entry_port,
  input  wire logic [31:0]                      dest_addr,
  input  wire logic [7:0]                       protocol,
  input  wire logic [7:0]                       ttl,
  input  wire logic [7:0]                       icmp_kind,
  input  wire logic                             icmp_ok,
  input  wire logic                             requeued,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [2:0]                            action,
  output logic [1:0]                            out_port,
  output logic [31:0]                           next_hop,
  output logic [7:0]                            new_ttl,
  output logic [1:0]                            local_port
);

  logic                adv;
  ifd_pkg::route_tok_t tok [ROUTES+1];

  assign item_stall = !adv;

  ifd_head #(
    .PORTS(PORTS)
  ) u_head (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .opcode       (opcode),
    .entry_index  (entry_index),
    .entry_dest   (entry_dest),
    .entry_mask   (entry_mask),
    .entry_gateway(entry_gateway),
    .entry_port   (entry_port),
    .dest_addr    (dest_addr),
    .protocol     (protocol),
    .ttl          (ttl),
    .icmp_kind    (icmp_kind),
    .icmp_ok      (icmp_ok),
    .requeued     (requeued),
    .tok_out      (tok[0])
  );

  for (genvar r = 0; r < ROUTES; r++) begin : g_cell
    ifd_cell #(
      .INDEX(r)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .tok_in (tok[r]),
      .tok_out(tok[r+1])
    );
  end

  ifd_tail u_tail (
    .clk         (clk),
    .rst         (rst),
    .tok_in      (tok[ROUTES]),
    .result_stall(result_stall),
    .adv         (adv),
    .result_valid(result_valid),
    .action      (action),
    .out_port    (out_port),
    .next_hop    (next_hop),
    .new_ttl     (new_ttl),
    .local_port  (local_port)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the IPv4 forwarding decision block.
// It depends on ifd_pkg and ipv4_forwarding_decision. It predicts every result from its
// own copy of the route table and interface settings, and checks results in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ifd_pkg::*;

  localparam int ROUTES = ROUTES_DEFAULT;
  localparam int PORTS  = PORTS_DEFAULT;
  localparam int LATENCY = ROUTES + 2;

  typedef struct {
    op_t         opcode;
    logic [3:0]  entry_index;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [1:0]  entry_port;
    logic [31:0] dest_addr;
    logic [7:0]  protocol;
    logic [7:0]  ttl;
    logic [7:0]  icmp_kind;
    logic        icmp_ok;
    logic        requeued;
  } fwd_req_t;

  typedef struct {
    action_t     action;
    logic [1:0]  out_port;
    logic [31:0] next_hop;
    logic [7:0]  new_ttl;
    logic [1:0]  local_port;
  } fwd_resp_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   item_valid;
  logic                   item_stall;
  logic                   opcode;
  logic [3:0]             entry_index;
  logic [31:0]            entry_dest;
  logic [31:0]            entry_mask;
  logic [31:0]            entry_gateway;
  logic [1:0]             entry_port;
  logic [31:0]            dest_addr;
  logic [7:0]             protocol;
  logic [7:0]             ttl;
  logic [7:0]             icmp_kind;
  logic                   icmp_ok;
  logic                   requeued;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [2:0]             action;
  logic [1:0]             out_port;
  logic [31:0]            next_hop;
  logic [7:0]             new_ttl;
  logic [1:0]             local_port;

  // Predictor state: route table and interface settings as the block should hold them.
  logic [31:0] rt_dest [ROUTES];
  logic [31:0] rt_mask [ROUTES];
  logic [31:0] rt_gateway [ROUTES];
  logic [1:0]  rt_port [ROUTES];
  logic [31:0] if_addr [4];
  logic [3:0]  if_enable;

  fwd_resp_t pending_results[$];
  int        error_count = 0;
  bit        burst_mode = 1'b0;

  ipv4_forwarding_decision u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .entry_dest    (entry_dest),
    .entry_mask    (entry_mask),
    .entry_gateway (entry_gateway),
    .entry_port    (entry_port),
    .dest_addr     (dest_addr),
    .protocol      (protocol),
    .ttl           (ttl),
    .icmp_kind     (icmp_kind),
    .icmp_ok       (icmp_ok),
    .requeued      (requeued),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .action        (action),
    .out_port      (out_port),
    .next_hop      (next_hop),
    .new_ttl       (new_ttl),
    .local_port    (local_port)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Computes the decision for one transaction and applies route writes to the table.
  function automatic fwd_resp_t predict_forwarding(input fwd_req_t req);
    fwd_resp_t   resp;
    logic [31:0] best_mask;
    int          best;
    bit          found;
    logic [7:0]  ttl_after;
    resp.action = ACT_WRITE;
    resp.out_port = 2'd0;
    resp.next_hop = 32'd0;
    resp.new_ttl = 8'd0;
    resp.local_port = 2'd0;
    if (req.opcode == OP_WRITE) begin
      if (req.entry_index < ROUTES) begin
        rt_dest[req.entry_index] = req.entry_dest;
        rt_mask[req.entry_index] = req.entry_mask;
        rt_gateway[req.entry_index] = req.entry_gateway;
        rt_port[req.entry_index] = req.entry_port;
      end
      return resp;
    end
    for (int i = 0; i < PORTS && i < 4; i++) begin
      if (if_enable[i] && if_addr[i] == req.dest_addr) begin
        if (req.protocol == PROTO_ICMP) begin
          if (req.icmp_ok && req.icmp_kind == ICMP_ECHO_REQUEST) begin
            resp.action = ACT_ECHO;
            resp.local_port = 2'(i);
          end else begin
            resp.action = ACT_DROP;
          end
        end else if (req.protocol == PROTO_TCP || req.protocol == PROTO_UDP) begin
          resp.action = ACT_PORT_UNREACH;
          resp.local_port = 2'(i);
        end else begin
          resp.action = ACT_DROP;
        end
        return resp;
      end
    end
    found = 1'b0;
    best = 0;
    best_mask = 32'd0;
    // Only a strictly longer mask replaces the best, so the earliest entry wins a tie.
    for (int r = 0; r < ROUTES; r++) begin
      if ((rt_mask[r] & req.dest_addr) == rt_dest[r] && rt_mask[r] > best_mask) begin
        best_mask = rt_mask[r];
        best = r;
        found = 1'b1;
      end
    end
    if (!found) begin
      resp.action = ACT_NET_UNREACH;
      return resp;
    end
    ttl_after = req.requeued ? req.ttl : req.ttl - 8'd1;
    resp.next_hop = rt_gateway[best];
    resp.new_ttl = ttl_after;
    if (ttl_after == 8'd0) begin
      resp.action = ACT_TIME_EXCEEDED;
    end else begin
      resp.action = ACT_FORWARD;
      resp.out_port = rt_port[best];
    end
    return resp;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 50) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    fwd_resp_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with none outstanding");
      end else begin
        want = pending_results.pop_front();
        if (action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", action, want.action));
        if (out_port !== want.out_port)
          report_mismatch($sformatf("out_port %0d, want %0d", out_port, want.out_port));
        if (next_hop !== want.next_hop)
          report_mismatch($sformatf("next_hop %h, want %h", next_hop, want.next_hop));
        if (new_ttl !== want.new_ttl)
          report_mismatch($sformatf("new_ttl %0d, want %0d", new_ttl, want.new_ttl));
        if (local_port !== want.local_port)
          report_mismatch($sformatf("local_port %0d, want %0d", local_port, want.local_port));
      end
    end
  end

  always @(negedge clk) begin
    if (burst_mode) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < 21);
    end
  end

  // Called and returns at a falling edge; valid stays high for a following transaction.
  task automatic send_request(input fwd_req_t req);
    while (!burst_mode && $urandom_range(99) < 21) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    opcode <= req.opcode;
    entry_index <= req.entry_index;
    entry_dest <= req.entry_dest;
    entry_mask <= req.entry_mask;
    entry_gateway <= req.entry_gateway;
    entry_port <= req.entry_port;
    dest_addr <= req.dest_addr;
    protocol <= req.protocol;
    ttl <= req.ttl;
    icmp_kind <= req.icmp_kind;
    icmp_ok <= req.icmp_ok;
    requeued <= req.requeued;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(predict_forwarding(req));
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic apply_iface_setting(input logic [31:0] a0, input logic [31:0] a1,
                                     input logic [31:0] a2, input logic [31:0] a3,
                                     input logic [3:0] enable);
    logic [31:0] addrs [4];
    addrs[0] = a0;
    addrs[1] = a1;
    addrs[2] = a2;
    addrs[3] = a3;
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IFACE_ADDR_0 + CFG_INDEX_W'(i);
      cfg_data <= addrs[i];
      if_addr[i] = addrs[i];
      @(negedge clk);
    end
    cfg_write <= 1'b1;
    cfg_index <= CFG_IFACE_ENABLE;
    cfg_data <= CFG_DATA_W'(enable);
    if_enable = enable;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic fwd_req_t random_req();
    fwd_req_t req;
    req.opcode = op_t'($urandom_range(1));
    req.entry_index = 4'($urandom_range(15));
    req.entry_dest = $urandom();
    req.entry_mask = $urandom();
    req.entry_gateway = $urandom();
    req.entry_port = 2'($urandom_range(3));
    req.dest_addr = $urandom();
    req.protocol = 8'($urandom_range(255));
    req.ttl = 8'($urandom_range(255));
    req.icmp_kind = 8'($urandom_range(255));
    req.icmp_ok = 1'($urandom_range(1));
    req.requeued = 1'($urandom_range(1));
    return req;
  endfunction

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'd0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  task automatic write_route(input logic [3:0] slot, input logic [31:0] dest,
                             input logic [31:0] mask, input logic [31:0] gateway,
                             input logic [1:0] port);
    fwd_req_t req;
    req = random_req();
    req.opcode = OP_WRITE;
    req.entry_index = slot;
    req.entry_dest = dest;
    req.entry_mask = mask;
    req.entry_gateway = gateway;
    req.entry_port = port;
    send_request(req);
  endtask

  task automatic decide(input logic [31:0] dest, input logic [7:0] proto,
                        input logic [7:0] ttl_in, input logic [7:0] itype,
                        input logic ok, input logic rq);
    fwd_req_t req;
    req = random_req();
    req.opcode = OP_DECIDE;
    req.dest_addr = dest;
    req.protocol = proto;
    req.ttl = ttl_in;
    req.icmp_kind = itype;
    req.icmp_ok = ok;
    req.requeued = rq;
    send_request(req);
  endtask

  // Every slot gets written once with mask zero, so no lookup compares a stale entry.
  task automatic test_table_init();
    for (int s = 0; s < ROUTES; s++) begin
      write_route(4'(s), $urandom(), 32'd0, $urandom(), 2'($urandom_range(3)));
    end
  endtask

  task automatic test_no_route();
    drain_results();
    apply_iface_setting(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
    decide(32'd0, PROTO_TCP, 8'd64, 8'd0, 1'b1, 1'b0);
    decide(32'hFFFF_FFFF, PROTO_ICMP, 8'd1, ICMP_ECHO_REQUEST, 1'b1, 1'b0);
  endtask

  task automatic test_local_delivery();
    drain_results();
    // Interfaces 0 and 1 share an address but 0 is disabled, so 1 must answer.
    apply_iface_setting(32'hC0A8_0001, 32'hC0A8_0001, 32'hC0A8_0101, 32'hFFFF_FFFF, 4'hE);
    decide(32'hC0A8_0001, PROTO_ICMP, 8'd9, ICMP_ECHO_REQUEST, 1'b1, 1'b0);
    decide(32'hC0A8_0001, PROTO_ICMP, 8'd9, ICMP_ECHO_REQUEST, 1'b0, 1'b0);
    decide(32'hC0A8_0001, PROTO_ICMP, 8'd9, 8'd0, 1'b1, 1'b1);
    decide(32'hC0A8_0001, PROTO_TCP, 8'd0, 8'd0, 1'b0, 1'b0);
    decide(32'hC0A8_0001, PROTO_UDP, 8'd255, 8'hFF, 1'b1, 1'b1);
    decide(32'hC0A8_0001, 8'hFF, 8'd1, ICMP_ECHO_REQUEST, 1'b1, 1'b0);
    decide(32'hC0A8_0101, PROTO_TCP, 8'd1, 8'd0, 1'b0, 1'b0);
    decide(32'hFFFF_FFFF, PROTO_UDP, 8'd1, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic test_route_selection();
    write_route(4'd0, 32'h0A00_0000, prefix_mask(8), 32'h0A00_0001, 2'd0);
    write_route(4'd1, 32'h0A01_0000, prefix_mask(16), 32'h0A01_0001, 2'd1);
    write_route(4'd2, 32'h0A01_0000, prefix_mask(16), 32'h0A01_0002, 2'd2);
    write_route(4'd3, 32'h0A01_0203, prefix_mask(32), 32'hFFFF_FFFE, 2'd3);
    write_route(4'd15, 32'hFFFF_FFFF, prefix_mask(32), 32'h0000_0000, 2'd3);
    // The interface address still wins over a route that covers it.
    write_route(4'd6, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_FFFF, 2'd2);
    decide(32'h0A09_0909, PROTO_TCP, 8'd64, 8'd0, 1'b0, 1'b0);
    decide(32'h0A01_0909, PROTO_UDP, 8'd1, 8'd0, 1'b0, 1'b0);
    decide(32'h0A01_0203, PROTO_TCP, 8'd0, 8'd0, 1'b0, 1'b0);
    decide(32'h0A01_0203, PROTO_TCP, 8'd0, 8'd0, 1'b0, 1'b1);
    decide(32'h0A01_0204, PROTO_ICMP, 8'd7, ICMP_ECHO_REQUEST, 1'b1, 1'b1);
    decide(32'h0B00_0000, PROTO_TCP, 8'd64, 8'd0, 1'b0, 1'b0);
    decide(32'hFFFF_FFFF, PROTO_TCP, 8'd255, 8'd0, 1'b0, 1'b0);
    decide(32'hC0A8_0101, PROTO_TCP, 8'd64, 8'd0, 1'b0, 1'b0);
    decide(32'hC0A8_0505, 8'd0, 8'd2, 8'd0, 1'b0, 1'b0);
  endtask

  // Mostly lookups aimed at interfaces or installed prefixes; some route writes.
  task automatic run_random_traffic(input int count);
    fwd_req_t req;
    int       sel;
    int       slot;
    int       kind;
    repeat (count) begin
      req = random_req();
      sel = $urandom_range(99);
      if (sel < 15) begin
        req.opcode = OP_WRITE;
        kind = $urandom_range(9);
        if (kind == 0) begin
          req.entry_mask = 32'd0;
        end else if (kind > 1) begin
          req.entry_mask = prefix_mask($urandom_range(32, 1));
        end
        if ($urandom_range(3) != 0) req.entry_dest = req.entry_dest & req.entry_mask;
      end else begin
        req.opcode = OP_DECIDE;
        if (sel < 35) begin
          req.dest_addr = if_addr[$urandom_range(3)];
        end else if (sel < 85) begin
          slot = $urandom_range(ROUTES - 1);
          req.dest_addr = rt_dest[slot] | (req.dest_addr & ~rt_mask[slot]);
        end
        case ($urandom_range(4))
          0: req.protocol = PROTO_ICMP;
          1: req.protocol = PROTO_TCP;
          2: req.protocol = PROTO_UDP;
          default: ;
        endcase
        if ($urandom_range(1) != 0) req.icmp_kind = ICMP_ECHO_REQUEST;
        case ($urandom_range(3))
          0: req.ttl = 8'($urandom_range(2));
          1: req.ttl = 8'hFF;
          default: ;
        endcase
      end
      send_request(req);
    end
  endtask

  task automatic test_random_settings();
    logic [31:0] shared;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      shared = $urandom();
      case (phase)
        0: apply_iface_setting($urandom(), $urandom(), $urandom(), $urandom(), 4'hF);
        1: apply_iface_setting($urandom(), $urandom(), $urandom(), $urandom(), 4'h0);
        2: apply_iface_setting(shared, shared, shared, shared, 4'hF);
        3: apply_iface_setting(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                               4'($urandom_range(15)));
        default: apply_iface_setting(rt_dest[$urandom_range(ROUTES - 1)], $urandom(),
                                     shared, shared, 4'($urandom_range(15)));
      endcase
      run_random_traffic(230);
    end
  endtask

  // Neither side idles here, so transactions follow each other in every cycle.
  task automatic test_back_to_back();
    burst_mode = 1'b1;
    run_random_traffic(150);
    burst_mode = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_IFACE_ENABLE;
    cfg_data = '0;
    item_valid = 1'b0;
    opcode = OP_WRITE;
    entry_index = '0;
    entry_dest = '0;
    entry_mask = '0;
    entry_gateway = '0;
    entry_port = '0;
    dest_addr = '0;
    protocol = '0;
    ttl = '0;
    icmp_kind = '0;
    icmp_ok = 1'b0;
    requeued = 1'b0;
    for (int s = 0; s < ROUTES; s++) begin
      rt_dest[s] = '0;
      rt_mask[s] = '0;
      rt_gateway[s] = '0;
      rt_port[s] = '0;
    end
    for (int i = 0; i < 4; i++) if_addr[i] = '0;
    if_enable = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_table_init();
    test_no_route();
    test_local_delivery();
    test_route_selection();
    test_random_settings();
    test_back_to_back();
    drain_results();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d transactions outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
